[rtl/core/car_pkg.sv]
// Shared types, constants and helper functions for the comb/allpass reverb.
`timescale 1ns / 1ps
package car_pkg;

  localparam int SMP_W  = 24;   // sample width
  localparam int CF_W   = 17;   // Q1.16 coefficient width (one included)
  localparam int SC_W   = 16;   // delay scale width, Q2.14
  localparam int BASE_W = 11;   // delay table entry width
  localparam int MA_W   = 25;   // shared multiplier, operand A
  localparam int MB_W   = 33;   // shared multiplier, operand B
  localparam int PROD_W = 58;
  localparam int ACC_W  = 60;
  localparam int SCALE_SH = 14;

  localparam logic [CF_W-1:0] Q16_ONE    = 17'd65536;
  localparam logic [CF_W-1:0] FB_BASE    = 17'd32768;
  localparam logic [CF_W-1:0] FB_SPAN    = 17'd29491;
  localparam logic [CF_W-1:0] RIGHT_GAIN = 17'd45875;

  localparam logic signed [ACC_W-1:0] HALF_Q16 = 60'sd32768;
  localparam logic signed [ACC_W-1:0] HALF_Q32 = 60'sd2147483648;
  localparam logic signed [ACC_W-1:0] S24_MAX  = 60'sd8388607;
  localparam logic signed [ACC_W-1:0] S24_MIN  = -60'sd8388608;

  typedef enum logic [1:0] {
    REG_ROOM  = 2'd0,
    REG_DAMP  = 2'd1,
    REG_MIX   = 2'd2,
    REG_SCALE = 2'd3
  } car_reg_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRE0,
    ST_PRE1,
    ST_PRE2,
    ST_CLEN,
    ST_CPOS,
    ST_CRD,
    ST_CY,
    ST_CLP1,
    ST_CLP2,
    ST_CFB,
    ST_CWR,
    ST_DIV,
    ST_AVG,
    ST_ALEN,
    ST_APOS,
    ST_ARD,
    ST_AZ,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3
  } car_state_e;

  function automatic logic [BASE_W-1:0] comb_base_f(input logic [2:0] k);
    logic [BASE_W-1:0] r;
    case (k)
      3'd0:    r = 11'd1116;
      3'd1:    r = 11'd1188;
      3'd2:    r = 11'd1277;
      3'd3:    r = 11'd1356;
      3'd4:    r = 11'd1422;
      3'd5:    r = 11'd1491;
      3'd6:    r = 11'd1557;
      default: r = 11'd1617;
    endcase
    return r;
  endfunction

  function automatic logic [BASE_W-1:0] ap_base_f(input logic [1:0] k);
    logic [BASE_W-1:0] r;
    case (k)
      2'd0:    r = 11'd556;
      2'd1:    r = 11'd441;
      2'd2:    r = 11'd341;
      default: r = 11'd225;
    endcase
    return r;
  endfunction

  function automatic logic signed [SMP_W-1:0] sat24_f(input logic signed [ACC_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > S24_MAX) begin
      r = S24_MAX[SMP_W-1:0];
    end else if (v < S24_MIN) begin
      r = S24_MIN[SMP_W-1:0];
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CF_W-1:0] clamp_q16_f(input logic [CF_W-1:0] v);
    return (v > Q16_ONE) ? Q16_ONE : v;
  endfunction

endpackage

[rtl/core/car_ram.sv]
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module car_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/comb_allpass_reverb.sv]
// Top level: mono-in, stereo-out comb/allpass reverb on one shared multiplier.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | in        | in_valid_i / in_ready_o    | sample_in_i
//  out     | out       | out_valid_o / out_ready_i  | left_out_o, right_out_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Per sample, each comb needs eight steps through the single multiplier and the
// single-port delay RAM, and the comb average is a reciprocal multiply in two passes.
// After reset a clearing pass zeroes both delay RAMs; no request is taken meanwhile.
// A stalled result holds in the output register; the last step waits there.
`timescale 1ns / 1ps
module comb_allpass_reverb
  import car_pkg::*;
#(
  parameter int COMB_COUNT        = 8,
  parameter int ALLPASS_COUNT     = 4,
  parameter int COMB_MAX_DEPTH    = 4096,
  parameter int ALLPASS_MAX_DEPTH = 2048
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SMP_W-1:0] sample_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SMP_W-1:0] left_out_o,
  output logic signed [SMP_W-1:0] right_out_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [CF_W-1:0]         cfg_data_i
);

  localparam int COMB_TOTAL = COMB_COUNT * COMB_MAX_DEPTH;
  localparam int AP_TOTAL   = ALLPASS_COUNT * ALLPASS_MAX_DEPTH;
  localparam int CLR_TOTAL  = (COMB_TOTAL > AP_TOTAL) ? COMB_TOTAL : AP_TOTAL;
  localparam int CLR_W      = $clog2(CLR_TOTAL);
  localparam int CA_W       = $clog2(COMB_TOTAL);
  localparam int AA_W       = $clog2(AP_TOTAL);
  localparam int CI_W       = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
  localparam int AI_W       = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
  localparam int CP_W       = $clog2(COMB_MAX_DEPTH);
  localparam int CL_W       = CP_W + 1;
  localparam int AP_W       = $clog2(ALLPASS_MAX_DEPTH);
  localparam int AL_W       = AP_W + 1;
  localparam int LR_W       = PROD_W - SCALE_SH;
  localparam int SUM_W      = SMP_W + $clog2(COMB_COUNT) + 1;
  localparam int DC_W       = 1;
  // floor(u/COMB_COUNT) = (u*DIV_RCP) >> DIV_SH, exact for every biased comb sum
  localparam int DIV_SH     = 31;
  localparam int DIV_LO_W   = MA_W - 1;
  localparam logic [MB_W-1:0] DIV_RCP =
    MB_W'(((64'd1 << DIV_SH) + 64'(COMB_COUNT) - 64'd1) / 64'(COMB_COUNT));

  // configuration
  logic [CF_W-1:0] room_q, damp_q, mix_q;
  logic [SC_W-1:0] scale_q;
  logic [CF_W-1:0] room_c, damp_c, mix_c;

  // control
  car_state_e      state_q, state_d;
  logic [CLR_W-1:0] clr_cnt_q;
  logic [CI_W-1:0] ci_q;
  logic [AI_W-1:0] ai_q;
  logic [DC_W-1:0] div_cnt_q;
  logic            out_valid_q;
  logic            ci_last, ai_last, div_last, clr_last, out_fire;

  // per-stage state
  logic signed [SMP_W-1:0] lp_q   [COMB_COUNT];
  logic [CP_W-1:0]         cpos_arr_q [COMB_COUNT];
  logic [AP_W-1:0]         apos_arr_q [ALLPASS_COUNT];

  // datapath
  logic signed [SMP_W-1:0]  x_q, w_q, left_hold_q, left_q, right_q;
  logic [CF_W-1:0]          fb_q;
  logic signed [MB_W-1:0]   mg_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]         div_u_q;
  logic                     neg_q;
  logic [CL_W-1:0]          clen_q;
  logic [CP_W-1:0]          cpos_q;
  logic [CA_W-1:0]          caddr_q;
  logic [AL_W-1:0]          alen_q;
  logic [AP_W-1:0]          apos_q;
  logic [AA_W-1:0]          aaddr_q;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  logic               cram_we, aram_we;
  logic [CA_W-1:0]    cram_addr;
  logic [AA_W-1:0]    aram_addr;
  logic [SMP_W-1:0]   cram_wdata, aram_wdata, cram_rdata, aram_rdata;

  logic [LR_W-1:0]         len_raw;
  logic [CL_W-1:0]         clen_c;
  logic [AL_W-1:0]         alen_c;
  logic [CP_W-1:0]         cpos_sel;
  logic [AP_W-1:0]         apos_sel;
  logic [CP_W-1:0]         cpos_next;
  logic [AP_W-1:0]         apos_next;
  logic signed [SMP_W-1:0] c_store, lp_new, ap_store, ap_out, z_s, y_s;
  logic signed [SMP_W-1:0] right_c;
  logic signed [ACC_W-1:0] avg_c;
  logic [CI_W+2:0]         ci_ext;
  logic [AI_W+1:0]         ai_ext;

  assign room_c = clamp_q16_f(room_q);
  assign damp_c = clamp_q16_f(damp_q);
  assign mix_c  = clamp_q16_f(mix_q);

  assign ci_last  = (ci_q == CI_W'(COMB_COUNT - 1));
  assign ai_last  = (ai_q == AI_W'(ALLPASS_COUNT - 1));
  assign div_last = (div_cnt_q == DC_W'(1));
  assign clr_last = (clr_cnt_q == CLR_W'(CLR_TOTAL - 1));
  assign out_fire = (state_q == ST_F3) && (!out_valid_q || out_ready_i);

  assign ci_ext = {3'b000, ci_q};
  assign ai_ext = {2'b00, ai_q};

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

  // delay lengths, clamped to 1..max depth
  assign len_raw = prod_q[PROD_W-1:SCALE_SH];
  always_comb begin
    if (len_raw == '0) begin
      clen_c = CL_W'(1);
      alen_c = AL_W'(1);
    end else begin
      clen_c = (len_raw > LR_W'(COMB_MAX_DEPTH)) ? CL_W'(COMB_MAX_DEPTH) : len_raw[CL_W-1:0];
      alen_c = (len_raw > LR_W'(ALLPASS_MAX_DEPTH)) ? AL_W'(ALLPASS_MAX_DEPTH)
                                                     : len_raw[AL_W-1:0];
    end
  end

  assign cpos_sel  = ({1'b0, cpos_arr_q[ci_q]} >= clen_c) ? '0 : cpos_arr_q[ci_q];
  assign apos_sel  = ({1'b0, apos_arr_q[ai_q]} >= alen_c) ? '0 : apos_arr_q[ai_q];
  assign cpos_next = ((CL_W'(cpos_q) + CL_W'(1)) >= clen_q) ? '0 : cpos_q + CP_W'(1);
  assign apos_next = ((AL_W'(apos_q) + AL_W'(1)) >= alen_q) ? '0 : apos_q + AP_W'(1);

  assign y_s = cram_rdata;
  assign z_s = aram_rdata;

  assign lp_new  = sat24_f((acc_q + ACC_W'(prod_q) + HALF_Q16) >>> 16);
  assign c_store = sat24_f(ACC_W'(x_q) + ((ACC_W'(prod_q) + HALF_Q16) >>> 16));
  assign ap_store = sat24_f(ACC_W'(w_q) + (ACC_W'(z_s) >>> 1));
  assign ap_out   = sat24_f(ACC_W'(z_s) - ACC_W'(w_q));
  assign right_c  = sat24_f(((acc_q <<< 16) - ACC_W'(prod_q) + HALF_Q32) >>> 32);

  // high partial product sits shifted in acc_q, low one in prod_q
  assign avg_c = (acc_q + ACC_W'(prod_q)) >>> DIV_SH;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_PRE0;
      ST_PRE0:  state_d = ST_PRE1;
      ST_PRE1:  state_d = ST_PRE2;
      ST_PRE2:  state_d = ST_CLEN;
      ST_CLEN:  state_d = ST_CPOS;
      ST_CPOS:  state_d = ST_CRD;
      ST_CRD:   state_d = ST_CY;
      ST_CY:    state_d = ST_CLP1;
      ST_CLP1:  state_d = ST_CLP2;
      ST_CLP2:  state_d = ST_CFB;
      ST_CFB:   state_d = ST_CWR;
      ST_CWR:   state_d = ci_last ? ST_DIV : ST_CLEN;
      ST_DIV:   if (div_last) state_d = ST_AVG;
      ST_AVG:   state_d = ST_ALEN;
      ST_ALEN:  state_d = ST_APOS;
      ST_APOS:  state_d = ST_ARD;
      ST_ARD:   state_d = ST_AZ;
      ST_AZ:    state_d = ai_last ? ST_F0 : ST_ALEN;
      ST_F0:    state_d = ST_F1;
      ST_F1:    state_d = ST_F2;
      ST_F2:    state_d = ST_F3;
      ST_F3:    if (out_fire) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // multiplier operands and RAM control
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    cram_we    = 1'b0;
    aram_we    = 1'b0;
    cram_addr  = caddr_q;
    aram_addr  = aaddr_q;
    cram_wdata = c_store;
    aram_wdata = ap_store;
    case (state_q)
      ST_CLEAR: begin
        cram_we    = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(COMB_TOTAL));
        aram_we    = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(AP_TOTAL));
        cram_addr  = clr_cnt_q[CA_W-1:0];
        aram_addr  = clr_cnt_q[AA_W-1:0];
        cram_wdata = '0;
        aram_wdata = '0;
      end
      ST_PRE0: begin
        mul_a = MA_W'(FB_SPAN);
        mul_b = MB_W'(room_c);
      end
      ST_PRE1: begin
        mul_a = MA_W'(mix_c);
        mul_b = MB_W'(RIGHT_GAIN);
      end
      ST_CLEN: begin
        mul_a = MA_W'(comb_base_f(ci_ext[2:0]));
        mul_b = MB_W'(scale_q);
      end
      ST_CY: begin
        mul_a = MA_W'(y_s);
        mul_b = MB_W'(Q16_ONE - damp_c);
      end
      ST_CLP1: begin
        mul_a = MA_W'(lp_q[ci_q]);
        mul_b = MB_W'(damp_c);
      end
      ST_CFB: begin
        mul_a = MA_W'(lp_q[ci_q]);
        mul_b = MB_W'(fb_q);
      end
      ST_CWR:  cram_we = 1'b1;
      ST_DIV: begin
        mul_a = div_last ? MA_W'(div_u_q[DIV_LO_W-1:0])
                         : MA_W'(div_u_q[SUM_W-1:DIV_LO_W]);
        mul_b = DIV_RCP;
      end
      ST_ALEN: begin
        mul_a = MA_W'(ap_base_f(ai_ext[1:0]));
        mul_b = MB_W'(scale_q);
      end
      ST_AZ:   aram_we = 1'b1;
      ST_F0: begin
        mul_a = MA_W'(x_q);
        mul_b = MB_W'(Q16_ONE - mix_c);
      end
      ST_F1: begin
        mul_a = MA_W'(w_q);
        mul_b = MB_W'(mix_c);
      end
      ST_F2, ST_F3: begin
        mul_a = MA_W'(w_q);
        mul_b = mg_q;
      end
      default: ;
    endcase
  end

  // control state, configuration, filter states and positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      ci_q        <= '0;
      ai_q        <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      room_q      <= 17'd32768;
      damp_q      <= 17'd32768;
      mix_q       <= 17'd16384;
      scale_q     <= 16'd16384;
      for (int i = 0; i < COMB_COUNT; i++) begin
        lp_q[i]       <= '0;
        cpos_arr_q[i] <= '0;
      end
      for (int j = 0; j < ALLPASS_COUNT; j++) begin
        apos_arr_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + CLR_W'(1);
      end
      if (state_q == ST_CLP2) begin
        lp_q[ci_q] <= lp_new;
      end
      if (state_q == ST_CWR) begin
        cpos_arr_q[ci_q] <= cpos_next;
        ci_q             <= ci_last ? '0 : ci_q + CI_W'(1);
        div_cnt_q        <= '0;
      end
      if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + DC_W'(1);
      end
      if (state_q == ST_AZ) begin
        apos_arr_q[ai_q] <= apos_next;
        ai_q             <= ai_last ? '0 : ai_q + AI_W'(1);
      end
      if (out_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (car_reg_e'(cfg_index_i))
          REG_ROOM:  room_q <= cfg_data_i;
          REG_DAMP:  damp_q <= cfg_data_i;
          REG_MIX:   mix_q  <= cfg_data_i;
          REG_SCALE: begin
            scale_q <= cfg_data_i[SC_W-1:0];
            // new lengths: restart all taps and filter states
            for (int i = 0; i < COMB_COUNT; i++) begin
              lp_q[i]       <= '0;
              cpos_arr_q[i] <= '0;
            end
            for (int j = 0; j < ALLPASS_COUNT; j++) begin
              apos_arr_q[j] <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    case (state_q)
      ST_IDLE: begin
        x_q   <= sample_in_i;
        sum_q <= '0;
      end
      ST_PRE1: fb_q <= FB_BASE + CF_W'((ACC_W'(prod_q) + HALF_Q16) >>> 16);
      ST_PRE2: mg_q <= prod_q[MB_W-1:0];
      ST_CPOS: begin
        clen_q  <= clen_c;
        cpos_q  <= cpos_sel;
        caddr_q <= CA_W'(ci_q) * CA_W'(COMB_MAX_DEPTH) + CA_W'(cpos_sel);
      end
      ST_CY:   sum_q <= sum_q + SUM_W'(y_s);
      ST_CLP1: acc_q <= ACC_W'(prod_q);
      ST_CWR: begin
        // floor division: bias negative sums, divide magnitudes, negate back
        neg_q   <= sum_q[SUM_W-1];
        div_u_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) + SUM_W'(COMB_COUNT - 1) : sum_q;
      end
      ST_DIV: if (div_last) acc_q <= ACC_W'(prod_q) <<< DIV_LO_W;
      ST_AVG:  w_q <= neg_q ? SMP_W'(-avg_c) : SMP_W'(avg_c);
      ST_APOS: begin
        alen_q  <= alen_c;
        apos_q  <= apos_sel;
        aaddr_q <= AA_W'(ai_q) * AA_W'(ALLPASS_MAX_DEPTH) + AA_W'(apos_sel);
      end
      ST_AZ:   w_q <= ap_out;
      ST_F1:   acc_q <= ACC_W'(prod_q);
      ST_F2:   left_hold_q <= sat24_f((acc_q + ACC_W'(prod_q) + HALF_Q16) >>> 16);
      default: ;
    endcase
    if (out_fire) begin
      left_q  <= left_hold_q;
      right_q <= right_c;
    end
  end

  car_ram #(
    .WIDTH(SMP_W),
    .DEPTH(COMB_TOTAL)
  ) u_comb_ram (
    .clk_i  (clk_i),
    .we_i   (cram_we),
    .addr_i (cram_addr),
    .wdata_i(cram_wdata),
    .rdata_o(cram_rdata)
  );

  car_ram #(
    .WIDTH(SMP_W),
    .DEPTH(AP_TOTAL)
  ) u_ap_ram (
    .clk_i  (clk_i),
    .we_i   (aram_we),
    .addr_i (aram_addr),
    .wdata_i(aram_wdata),
    .rdata_o(aram_rdata)
  );

endmodule

[rtl/core/car_chk.sv]
// Port-level checks for the reverb top level, bound into it.
`timescale 1ns / 1ps
module car_chk
  import car_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [SMP_W-1:0] left_out_o,
  input logic signed [SMP_W-1:0] right_out_o
);

  // a taken request keeps the block busy for the following cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready_o high right after a request");

  // no result can appear in the cycle after a request
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared right after a request");

  // a new result only comes at the end of a sample, with the block free again
  a_result_then_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised while block still busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(left_out_o) && $stable(right_out_o))
    else $error("stalled result changed");

endmodule

bind comb_allpass_reverb car_chk u_car_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .left_out_o (left_out_o),
  .right_out_o(right_out_o)
);

[tb/tb.sv]
// Self-checking testbench for the comb/allpass reverb: directed table, then random phases.
`timescale 1ns / 1ps
module tb;
  import car_pkg::*;

  localparam int NCOMB = 8;
  localparam int NAP = 4;
  localparam int CDEPTH = 4096;
  localparam int ADEPTH = 2048;
  localparam int DRAIN_WAIT = 150;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
  } stereo_t;

  typedef struct {
    logic signed [SMP_W-1:0] smp;
    bit                      typed;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [SMP_W-1:0] sample_in_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [SMP_W-1:0] left_out_o;
  logic signed [SMP_W-1:0] right_out_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [1:0]              cfg_index_i = '0;
  logic [CF_W-1:0]         cfg_data_i = '0;

  comb_allpass_reverb dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("comb_allpass_reverb: mismatch");
    $finish;
  end

  // reverb model state
  logic [CF_W-1:0] room_r, damp_r, mix_r;
  logic [SC_W-1:0] scale_r;
  longint comb_mem [NCOMB*CDEPTH];
  longint ap_mem [NAP*ADEPTH];
  longint lp_st [NCOMB];
  int unsigned comb_pos [NCOMB];
  int unsigned ap_pos [NAP];

  stereo_t expected_q [$];
  int errors = 0;
  bit quiet = 0;
  bit hold_go = 0;

  function automatic longint sat24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clampq(logic [CF_W-1:0] v);
    return (v > 17'd65536) ? 65536 : longint'(v);
  endfunction

  function automatic int unsigned tap_len(int unsigned base, int unsigned maxd);
    int unsigned len;
    len = (base * scale_r) >> 14;
    if (len < 1) len = 1;
    if (len > maxd) len = maxd;
    return len;
  endfunction

  function automatic stereo_t reverb_step(logic signed [SMP_W-1:0] smp);
    int unsigned cbase [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
    int unsigned abase [4] = '{556, 441, 341, 225};
    longint x, d, m, fb, sum, w, y, z, dry;
    int unsigned len, pos, idx;
    stereo_t res;
    x = smp;
    d = clampq(damp_r);
    m = clampq(mix_r);
    fb = 32768 + rshift(clampq(room_r) * 29491, 16);
    sum = 0;
    for (int i = 0; i < NCOMB; i++) begin
      len = tap_len(cbase[i % 8], CDEPTH);
      pos = comb_pos[i];
      if (pos >= len) pos = 0;
      idx = i * CDEPTH + pos;
      y = comb_mem[idx];
      lp_st[i] = sat24(rshift(y * (65536 - d) + lp_st[i] * d, 16));
      comb_mem[idx] = sat24(x + rshift(lp_st[i] * fb, 16));
      pos++;
      comb_pos[i] = (pos >= len) ? 0 : pos;
      sum += y;
    end
    w = sum >>> 3;
    for (int i = 0; i < NAP; i++) begin
      len = tap_len(abase[i % 4], ADEPTH);
      pos = ap_pos[i];
      if (pos >= len) pos = 0;
      idx = i * ADEPTH + pos;
      z = ap_mem[idx];
      ap_mem[idx] = sat24(w + (z >>> 1));
      w = sat24(z - w);
      pos++;
      ap_pos[i] = (pos >= len) ? 0 : pos;
    end
    dry = 65536 - m;
    res.left = SMP_W'(sat24(rshift(x * dry + w * m, 16)));
    res.right = SMP_W'(sat24(rshift(x * dry * 65536 - w * m * 45875, 32)));
    return res;
  endfunction

  task automatic clear_taps();
    for (int i = 0; i < NCOMB; i++) begin
      lp_st[i] = 0;
      comb_pos[i] = 0;
    end
    for (int i = 0; i < NAP; i++) ap_pos[i] = 0;
  endtask

  // stops offering requests, then waits for every outstanding result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(car_reg_e idx, logic [CF_W-1:0] val);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ROOM:  room_r = val;
      REG_DAMP:  damp_r = val;
      REG_MIX:   mix_r = val;
      REG_SCALE: begin
        scale_r = val[SC_W-1:0];
        clear_taps();
      end
      default: ;
    endcase
  endtask

  // in_valid stays high between back-to-back requests; lowered only while idling
  task automatic send_sample(logic signed [SMP_W-1:0] smp, bit typed);
    stereo_t pred;
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    pred = reverb_step(smp);
    // with mix at zero both channels carry the dry sample unchanged
    if (typed) pred = '{left: smp, right: smp};
    expected_q.push_back(pred);
  endtask

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return SMP_W'($urandom_range(255) - 128);
      default: return SMP_W'($urandom());
    endcase
  endfunction

  function automatic logic [CF_W-1:0] rand_coef();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return CF_W'($urandom_range(17'h1FFFF));
    endcase
  endfunction

  function automatic logic [CF_W-1:0] rand_scale();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return 17'h0FFFF;
      2: return 17'h1FFFF;
      3: return CF_W'($urandom_range(17'h1FFFF));
      default: return CF_W'($urandom_range(600));
    endcase
  endfunction

  // result side: checks and randomized ready with an optional long hold-off
  initial begin
    int hold_cnt;
    stereo_t exp_v;
    hold_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result l=%0d r=%0d", left_out_o, right_out_o);
        end else begin
          exp_v = expected_q.pop_front();
          if (left_out_o !== exp_v.left || right_out_o !== exp_v.right) begin
            errors++;
            if (errors <= 10)
              $display("result error: exp l=%0d r=%0d got l=%0d r=%0d",
                       exp_v.left, exp_v.right, left_out_o, right_out_o);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (hold_go) begin
        hold_go = 0;
        hold_cnt = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || ($urandom_range(99) >= 10);
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    int nitems;
    room_r = 17'd32768;
    damp_r = 17'd32768;
    mix_r = 17'd16384;
    scale_r = 16'd16384;
    foreach (comb_mem[i]) comb_mem[i] = 0;
    foreach (ap_mem[i]) ap_mem[i] = 0;
    clear_taps();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    rows = '{'{24'sd0, 1}, '{24'sd1, 1}, '{-24'sd1, 1}, '{24'sh7FFFFF, 1},
             '{24'sh800000, 1}, '{24'sh555555, 1}, '{24'shAAAAAA, 1},
             '{24'sh7FFFFF, 1}, '{24'sh7FFFFF, 1}, '{24'sh800000, 1},
             '{24'sh800000, 1}, '{24'sh000100, 1}};

    // first pass at reset settings, then dry-only with expected typed in
    send_sample(24'sh400000, 0);
    write_reg(REG_MIX, 17'd0);
    foreach (rows[i]) send_sample(rows[i].smp, rows[i].typed);
    // full wet, coefficients above one, shortest delay lines
    write_reg(REG_MIX, 17'h1FFFF);
    write_reg(REG_ROOM, 17'h1FFFF);
    write_reg(REG_DAMP, 17'd0);
    write_reg(REG_SCALE, 17'd0);
    foreach (rows[i]) send_sample(rows[i].smp, 0);
    // longest lines, clamped to the maximum depth
    write_reg(REG_SCALE, 17'h0FFFF);
    write_reg(REG_DAMP, 17'd65536);
    foreach (rows[i]) send_sample(rows[i].smp, 0);

    nitems = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ROOM, rand_coef());
      write_reg(REG_DAMP, rand_coef());
      write_reg(REG_MIX, rand_coef());
      write_reg(REG_SCALE, rand_scale());
      quiet = (ph == 1);
      for (int k = 0; k < 85; k++) begin
        if (ph == 2 && k == 10) hold_go = 1;
        if (ph == 3 && k == 40) wait_drained();
        send_sample(rand_sample(), 0);
        nitems++;
      end
    end
    quiet = 0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("comb_allpass_reverb: match");
    end else begin
      $display("comb_allpass_reverb: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/car_pkg.sv
rtl/core/car_ram.sv
rtl/core/comb_allpass_reverb.sv
rtl/core/car_chk.sv
tb/tb.sv
